FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold whenever antecedent holds
`define CHECK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/dxr_pkg.sv
// shared types and constants for the disparity reprojection pipeline
package dxr_pkg;

  localparam int QW = 32;   // quotient and numerator bits, one cell per bit
  localparam int DW = 15;   // magnitude of a positive disparity

  localparam logic [23:0] XY_MAX = 24'h7fffff;
  localparam logic [23:0] XY_MIN = 24'h800000;
  localparam logic [23:0] Z_MAX  = 24'hffffff;

  typedef enum logic [1:0] {
    REG_FOCAL  = 2'd0,
    REG_BASE   = 2'd1,
    REG_CX     = 2'd2,
    REG_CY     = 2'd3
  } reg_idx_t;

  // one division lane: partial remainder and numerator bits shifted out
  // against quotient bits shifted in
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nq;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic          pvalid;
    logic          neg_x;
    logic          neg_y;
    logic [DW-1:0] d;
    lane_t [2:0]   ln;    // 0 = z, 1 = x, 2 = y
  } cell_t;

endpackage

FILE: rtl/dxr_cell.sv
// one restoring division step for the three lanes of a pipeline slot
module dxr_cell import dxr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t din,
  output cell_t dout
);

  cell_t nxt;
  logic [DW:0] trial [3];

  always_comb begin
    nxt = din;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {din.ln[i].rem, din.ln[i].nq[QW-1]};
      if (trial[i] >= {1'b0, din.d}) begin
        nxt.ln[i].rem = DW'(trial[i] - {1'b0, din.d});
        nxt.ln[i].nq  = {din.ln[i].nq[QW-2:0], 1'b1};
      end else begin
        nxt.ln[i].rem = trial[i][DW-1:0];
        nxt.ln[i].nq  = {din.ln[i].nq[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.pvalid <= nxt.pvalid;
      dout.neg_x  <= nxt.neg_x;
      dout.neg_y  <= nxt.neg_y;
      dout.d      <= nxt.d;
      dout.ln     <= nxt.ln;
    end
  end

endmodule

FILE: rtl/disparity_to_xyz_reprojection.sv
// top level: config registers, products, division cell chain, saturation
// Takes one disparity pixel per clock while not stalled and returns one 3D
// point per pixel, in order. The products f*b, |16u-cx|*b and |16v-cy|*b are
// formed and registered into the first chain slot, a row of 32 cells
// produces one quotient bit each for all three coordinates, and sign and
// saturation are applied into the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so a new
// pixel is accepted every cycle that m_tready is high. Registers should be
// written only while no pixel is in flight.
`include "assert_macros.svh"
module disparity_to_xyz_reprojection import dxr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_col[11:0], pixel_row[23:12], disparity[39:24]
  input  logic        s_tuser,   // disparity_infinite
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
  output logic        m_tuser    // point_valid
);

  logic [15:0] focal_length, baseline_mm, center_x, center_y;
  reg_idx_t    widx;
  logic        en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length <= 16'd8192;
      baseline_mm  <= 16'd100;
      center_x     <= 16'd0;
      center_y     <= 16'd0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_FOCAL: focal_length <= pwdata[15:0];
        REG_BASE:  baseline_mm  <= pwdata[15:0];
        REG_CX:    center_x     <= pwdata[15:0];
        REG_CY:    center_y     <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_FOCAL: prdata = {16'd0, focal_length};
      REG_BASE:  prdata = {16'd0, baseline_mm};
      REG_CX:    prdata = {16'd0, center_x};
      REG_CY:    prdata = {16'd0, center_y};
      default:   prdata = 32'd0;
    endcase
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front stage: offsets and products
  logic [11:0]        u, v;
  logic signed [15:0] disp;
  logic signed [17:0] ex, ey;
  logic [15:0]        ax, ay;
  cell_t              front;
  cell_t              chain [QW+1];

  assign u    = s_tdata[11:0];
  assign v    = s_tdata[23:12];
  assign disp = s_tdata[39:24];
  assign ex   = $signed({2'b00, u, 4'b0000}) - $signed({2'b00, center_x});
  assign ey   = $signed({2'b00, v, 4'b0000}) - $signed({2'b00, center_y});
  assign ax   = ex[17] ? 16'(-ex) : ex[15:0];
  assign ay   = ey[17] ? 16'(-ey) : ey[15:0];

  always_comb begin
    front.valid     = s_tvalid;
    front.pvalid    = !s_tuser && (disp > 16'sd0);
    front.neg_x     = ex[17];
    front.neg_y     = ey[17];
    front.d         = disp[DW-1:0];
    front.ln[0].rem = '0;
    front.ln[0].nq  = QW'(focal_length) * QW'(baseline_mm);
    front.ln[1].rem = '0;
    front.ln[1].nq  = QW'(ax) * QW'(baseline_mm);
    front.ln[2].rem = '0;
    front.ln[2].nq  = QW'(ay) * QW'(baseline_mm);
    // invalid pixels divide by one and are zeroed at the end
    if (!front.pvalid) begin
      front.d = DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= front.valid;
    end
    if (en) begin
      chain[0].pvalid <= front.pvalid;
      chain[0].neg_x  <= front.neg_x;
      chain[0].neg_y  <= front.neg_y;
      chain[0].d      <= front.d;
      chain[0].ln     <= front.ln;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    dxr_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // sign and saturation
  cell_t       last;
  logic [23:0] px, py, pz;
  logic [QW-1:0] qx, qy, qz;

  assign last = chain[QW];
  assign qz   = last.ln[0].nq;
  assign qx   = last.ln[1].nq;
  assign qy   = last.ln[2].nq;

  always_comb begin
    pz = (qz > QW'(Z_MAX)) ? Z_MAX : qz[23:0];
    if (last.neg_x) begin
      px = (qx >= QW'(XY_MIN)) ? XY_MIN : 24'(-qx[23:0]);
    end else begin
      px = (qx > QW'(XY_MAX)) ? XY_MAX : qx[23:0];
    end
    if (last.neg_y) begin
      py = (qy >= QW'(XY_MIN)) ? XY_MIN : 24'(-qy[23:0]);
    end else begin
      py = (qy > QW'(XY_MAX)) ? XY_MAX : qy[23:0];
    end
    if (!last.pvalid) begin
      px = '0;
      py = '0;
      pz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= last.valid;
    end
    if (en) begin
      m_tdata <= {pz, py, px};
      m_tuser <= last.pvalid;
    end
  end

  `CHECK_IMPLIES(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == 72'd0, "invalid point not zero")
  `CHECK_ALWAYS(a_ready_rule, s_tready == (!m_tvalid || m_tready), "input ready mismatch")
  `CHECK_IMPLIES(a_front_pvalid, front.pvalid, !s_tuser && !disp[15], "flag for bad disparity")

endmodule
